// ===== sv/note_sine_wavetable_player_macros.svh =====
// assertion macros for the note sine player
`ifndef NOTE_SINE_WAVETABLE_PLAYER_MACROS_SVH
`define NOTE_SINE_WAVETABLE_PLAYER_MACROS_SVH

// same-cycle implication, checked out of reset
`define NSWP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NSWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nswp_pkg.sv =====
// ---------------------------------------------------------------------------
// nswp_pkg
// Constants, key table and sine coefficients of the note sine player.
// ---------------------------------------------------------------------------
package nswp_pkg;

  localparam int NUM_KEYS     = 84;
  localparam int NOTE_SAMPLES = 22050;
  localparam int SAMPLE_RATE  = 44100;
  localparam int MAX_RUN      = 64;
  localparam int CUT_LIMIT    = 327;

  localparam logic [63:0] PHASE_DEN = 64'(100 * SAMPLE_RATE);
  localparam logic [63:0] PHASE_RND = 64'(50 * SAMPLE_RATE);

  localparam logic [31:0] PC1 = 32'd1686629713;
  localparam logic [31:0] PC3 = 32'd693598669;
  localparam logic [31:0] PC5 = 32'd85569306;
  localparam logic [31:0] PC7 = 32'd5026995;
  localparam logic [31:0] PC9 = 32'd172272;

  typedef logic [31:0] word_tab_t [NUM_KEYS];

  // note frequencies in hundredths of a hertz
  localparam word_tab_t CENTI_HZ = '{
    32'd6541, 32'd6930, 32'd7342, 32'd7778, 32'd8241, 32'd8731, 32'd9250, 32'd9800,
    32'd10383, 32'd11000, 32'd11654, 32'd12347, 32'd13081, 32'd13859, 32'd14683,
    32'd15556, 32'd16481, 32'd17461, 32'd18500, 32'd19600, 32'd20765, 32'd22000,
    32'd23308, 32'd24694, 32'd26163, 32'd27718, 32'd29366, 32'd31113, 32'd32963,
    32'd34923, 32'd36999, 32'd39200, 32'd41530, 32'd44000, 32'd46616, 32'd49388,
    32'd52325, 32'd55437, 32'd58733, 32'd62225, 32'd65925, 32'd69846, 32'd73999,
    32'd78399, 32'd83061, 32'd88000, 32'd93233, 32'd98777, 32'd104650, 32'd110873,
    32'd117466, 32'd124451, 32'd131851, 32'd139691, 32'd147998, 32'd156798,
    32'd166122, 32'd176000, 32'd186466, 32'd197553, 32'd209300, 32'd221746,
    32'd234932, 32'd248902, 32'd263702, 32'd279383, 32'd295996, 32'd313596,
    32'd332244, 32'd352000, 32'd372931, 32'd395107, 32'd418601, 32'd443492,
    32'd469863, 32'd497803, 32'd527404, 32'd558765, 32'd591991, 32'd627193,
    32'd664488, 32'd704000, 32'd745862, 32'd790213
  };

  // phase increment table, worked out at elaboration
  function automatic word_tab_t build_inc();
    word_tab_t   tab;
    logic [63:0] num;
    for (int k = 0; k < NUM_KEYS; k++) begin
      num    = ({32'd0, CENTI_HZ[k]} << 32) + PHASE_RND;
      tab[k] = 32'(num / PHASE_DEN);
    end
    return tab;
  endfunction

  localparam word_tab_t INC_TABLE = build_inc();

  typedef logic [31:0] coef_tab_t [4];
  localparam coef_tab_t POLY_COEF = '{PC7, PC5, PC3, PC1};

endpackage

// ===== sv/nswp_if.sv =====
// ---------------------------------------------------------------------------
// nswp_in_if / nswp_out_if
// Valid/ready channels of the note sine player.
// ---------------------------------------------------------------------------
interface nswp_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  key;
  logic [14:0] start_offset;
  logic [6:0]  count;
  logic [15:0] volume;
  modport source (output valid, key, start_offset, count, volume, input ready);
  modport sink   (input valid, key, start_offset, count, volume, output ready);
endinterface

interface nswp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               range_error;
  modport source (output valid, sample, last, range_error, input ready);
  modport sink   (input valid, sample, last, range_error, output ready);
endinterface

// ===== sv/nswp_mul.sv =====
// ---------------------------------------------------------------------------
// nswp_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module nswp_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ===== sv/note_sine_wavetable_player.sv =====
// ---------------------------------------------------------------------------
// note_sine_wavetable_player
// Equal-tempered sine note player with a per-key cutoff cache.
// ---------------------------------------------------------------------------
// One request at a time. Each sample takes eight multiplies on one shared
// registered multiplier (phase, x squared, four polynomial steps, final
// product, volume), then waits in the output state until the receiver is
// ready. The first request for a key after reset also walks backward from
// the note end to find its cutoff. Rejected requests give one error sample;
// an empty run with a valid key gives nothing.
`include "note_sine_wavetable_player_macros.svh"

module note_sine_wavetable_player (
  input logic        clk,
  input logic        rst_n,
  nswp_in_if.sink    in_ch,
  nswp_out_if.source out_ch
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_CHK  = 10'b0000000100,
    S_PH   = 10'b0000001000,
    S_X    = 10'b0000010000,
    S_X2   = 10'b0000100000,
    S_POLY = 10'b0001000000,
    S_SIN  = 10'b0010000000,
    S_VOL  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t       state_r, state_nxt;
  logic [6:0]   key_r;
  logic [14:0]  start_r;
  logic [6:0]   cnt_r;
  logic [15:0]  vol_r;
  logic [14:0]  n_r;
  logic [14:0]  cut_r;
  logic         walk_r;
  logic [1:0]   idx_r;
  logic [30:0]  x_r;
  logic [30:0]  x2_r;
  logic         neg_r;
  logic         out_valid_r;
  logic [15:0]  sample_r;
  logic         last_r;
  logic         err_r;

  logic [nswp_pkg::NUM_KEYS-1:0] cut_vld_r;
  logic [14:0] cut_mem [nswp_pkg::NUM_KEYS];
  logic [14:0] rd_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  logic        accept;
  logic        bad_req;
  logic [15:0] run_end;
  logic [31:0] phase;
  logic [30:0] x_nxt;
  logic [30:0] x2_nxt;
  logic [31:0] p_nxt;
  logic [32:0] s_rnd;
  logic [17:0] m_raw;
  logic [16:0] m_nxt;
  logic [32:0] r_rnd;
  logic [16:0] r_mag;
  logic [16:0] r_neg;
  logic [15:0] samp_nxt;
  logic        found;
  logic        wr_en;
  logic [14:0] wr_data;

  nswp_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample     = sample_r;
  assign out_ch.last       = last_r;
  assign out_ch.range_error = err_r;

  assign run_end = {1'b0, in_ch.start_offset} + {9'd0, in_ch.count};
  assign bad_req = (in_ch.key >= 7'(nswp_pkg::NUM_KEYS))
                || ((in_ch.count != 7'd0)
                    && ((in_ch.count > 7'(nswp_pkg::MAX_RUN))
                        || (run_end > 16'(nswp_pkg::NOTE_SAMPLES))));

  // sine datapath pieces
  assign phase  = prod_r[31:0];
  assign x_nxt  = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]})
                            : {1'b0, phase[29:0]};
  assign x2_nxt = prod_r[60:30];
  assign p_nxt  = nswp_pkg::POLY_COEF[idx_r] - prod_r[61:30];
  assign s_rnd  = {1'b0, prod_r[61:30]} + 33'd16384;
  assign m_raw  = s_rnd[32:15];
  assign m_nxt  = (m_raw > 18'd32768) ? 17'd32768 : m_raw[16:0];
  assign found  = (m_nxt <= 17'(nswp_pkg::CUT_LIMIT));

  assign r_rnd  = {1'b0, prod_r[31:0]} + 33'd16384;
  always_comb begin
    r_mag = (r_rnd[32:15] > 18'd65535) ? 17'h1ffff : r_rnd[31:15];
    r_neg = 17'd0;
    if (n_r > cut_r) begin
      samp_nxt = 16'd0;
    end else if (neg_r) begin
      if (r_mag > 17'd32768) begin
        r_mag = 17'd32768;
      end
      r_neg    = 17'd0 - r_mag;
      samp_nxt = r_neg[15:0];
    end else begin
      if (r_mag > 17'd32767) begin
        r_mag = 17'd32767;
      end
      samp_nxt = r_mag[15:0];
    end
  end

  assign wr_en   = (state_r == S_SIN) && walk_r && (found || (n_r == 15'd1));
  assign wr_data = found ? n_r : 15'd0;

  // multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_PH: begin
        mul_a = nswp_pkg::INC_TABLE[key_r];
        mul_b = {17'd0, n_r};
      end
      S_X: begin
        mul_a = {1'b0, x_nxt};
        mul_b = {1'b0, x_nxt};
      end
      S_X2: begin
        mul_a = nswp_pkg::PC9;
        mul_b = {1'b0, x2_nxt};
      end
      S_POLY: begin
        mul_a = p_nxt;
        mul_b = (idx_r == 2'd3) ? {1'b0, x_r} : {1'b0, x2_r};
      end
      S_SIN: begin
        mul_a = {15'd0, m_nxt};
        mul_b = {16'd0, vol_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bad_req) begin
            state_nxt = S_OUT;
          end else if (in_ch.count != 7'd0) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:   state_nxt = S_CHK;
      S_CHK:  state_nxt = S_PH;
      S_PH:   state_nxt = S_X;
      S_X:    state_nxt = S_X2;
      S_X2:   state_nxt = S_POLY;
      S_POLY: state_nxt = (idx_r == 2'd3) ? S_SIN : S_POLY;
      S_SIN:  state_nxt = walk_r ? S_PH : S_VOL;
      S_VOL:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = (last_r || err_r) ? S_IDLE : S_PH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      walk_r      <= 1'b0;
      cut_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && bad_req) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_VOL) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == S_OUT) && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_CHK) begin
        walk_r <= !cut_vld_r[key_r];
      end else if (wr_en) begin
        walk_r <= 1'b0;
      end
      if (wr_en) begin
        cut_vld_r[key_r] <= 1'b1;
      end
    end
  end

  // cutoff cache
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cut_mem[key_r] <= wr_data;
    end
    rd_q <= cut_mem[key_r];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= in_ch.key;
      start_r  <= in_ch.start_offset;
      cnt_r    <= in_ch.count;
      vol_r    <= in_ch.volume;
      sample_r <= 16'd0;
      last_r   <= 1'b1;
      err_r    <= bad_req;
    end
    case (state_r)
      S_CHK: begin
        cut_r <= rd_q;
        n_r   <= cut_vld_r[key_r] ? start_r : 15'(nswp_pkg::NOTE_SAMPLES - 1);
      end
      S_X: begin
        x_r   <= x_nxt;
        neg_r <= phase[31];
      end
      S_X2: begin
        x2_r  <= x2_nxt;
        idx_r <= 2'd0;
      end
      S_POLY: begin
        idx_r <= idx_r + 2'd1;
      end
      S_SIN: begin
        if (walk_r) begin
          if (wr_en) begin
            cut_r <= wr_data;
            n_r   <= start_r;
          end else begin
            n_r <= n_r - 15'd1;
          end
        end
      end
      S_VOL: begin
        sample_r <= samp_nxt;
        last_r   <= (cnt_r == 7'd1);
        err_r    <= 1'b0;
      end
      S_OUT: begin
        if (out_ch.ready && !last_r && !err_r) begin
          n_r   <= n_r + 15'd1;
          cnt_r <= cnt_r - 7'd1;
        end
      end
      default: begin
      end
    endcase
  end

  `NSWP_ASSERT_NOW(a_no_accept_while_out, out_valid_r, !in_ch.ready, "request taken with result pending")
  `NSWP_ASSERT_NOW(a_err_is_final_zero, out_valid_r && err_r, last_r && (sample_r == 16'd0), "error result not a final zero")
  `NSWP_ASSERT_NEXT(a_cache_marked, wr_en, cut_vld_r[key_r] && !walk_r, "cutoff write left entry invalid")

endmodule

// ===== test/note_sine_wavetable_player_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// note_sine_wavetable_player_tb
// Self-checking bench for the note sine player: directed requests cover bad
// keys, empty and oversized runs, field extremes and the zero region past the
// cutoff. Random requests follow, with random idling on both channels and one
// long hold-off on the result side. Every sample is checked in order against
// a fixed-point sine predictor with its own per-key cutoff cache.
// ---------------------------------------------------------------------------
module note_sine_wavetable_player_tb;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               range_error;
  } sample_exp_t;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int HOLD_CYCLES    = 3000;

  logic clk;
  logic rst_n;

  nswp_in_if  in_ch ();
  nswp_out_if out_ch ();

  note_sine_wavetable_player i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sample_exp_t expected_samples[$];
  logic [14:0] cut_cache[nswp_pkg::NUM_KEYS];
  logic        cut_known[nswp_pkg::NUM_KEYS];
  logic [14:0] cut_probe[nswp_pkg::NUM_KEYS];
  int          fast_keys[$];
  int          mismatches;
  int          checked;
  int          requests;
  int          hold_req;
  int          idle_cycles;
  bit          rx_idling_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] step_of(input int k);
    logic [63:0] num;
    num = ({32'd0, nswp_pkg::CENTI_HZ[k]} << 32) + 64'(50 * nswp_pkg::SAMPLE_RATE);
    return 32'(num / 64'(100 * nswp_pkg::SAMPLE_RATE));
  endfunction

  // quarter-wave polynomial, magnitude in Q15 plus sign
  function automatic logic [16:0] sine_mag(input logic [31:0] ph, output logic neg);
    logic [63:0] x, x2, p, s, m;
    x  = ph[30] ? (64'd1 << 30) - {34'd0, ph[29:0]} : {34'd0, ph[29:0]};
    x2 = (x * x) >> 30;
    p  = {32'd0, nswp_pkg::PC9};
    p  = {32'd0, nswp_pkg::PC7} - ((p * x2) >> 30);
    p  = {32'd0, nswp_pkg::PC5} - ((p * x2) >> 30);
    p  = {32'd0, nswp_pkg::PC3} - ((p * x2) >> 30);
    p  = {32'd0, nswp_pkg::PC1} - ((p * x2) >> 30);
    s  = (p * x) >> 30;
    m  = (s + 64'd16384) >> 15;
    if (m > 64'd32768) m = 64'd32768;
    neg = ph[31];
    return 17'(m);
  endfunction

  function automatic logic [14:0] walk_cutoff(input int k);
    logic [31:0] inc;
    logic        neg;
    inc = step_of(k);
    for (int n = nswp_pkg::NOTE_SAMPLES - 1; n > 0; n--) begin
      if (sine_mag(32'(n) * inc, neg) <= 17'(nswp_pkg::CUT_LIMIT)) return 15'(n);
    end
    return 15'd0;
  endfunction

  task automatic predict_request(input logic [6:0] key, input logic [14:0] start,
                                 input logic [6:0] cnt, input logic [15:0] vol);
    logic [31:0] inc;
    logic [16:0] m;
    logic [32:0] r;
    logic        neg;
    int          n;
    sample_exp_t e;
    if (key >= nswp_pkg::NUM_KEYS) begin
      expected_samples.push_back('{16'sd0, 1'b1, 1'b1});
      return;
    end
    if (cnt == 0) return;
    if (cnt > nswp_pkg::MAX_RUN || int'(start) + int'(cnt) > nswp_pkg::NOTE_SAMPLES) begin
      expected_samples.push_back('{16'sd0, 1'b1, 1'b1});
      return;
    end
    if (!cut_known[key]) begin
      cut_cache[key] = cut_probe[key];
      cut_known[key] = 1'b1;
    end
    inc = step_of(key);
    for (int i = 0; i < cnt; i++) begin
      n = int'(start) + i;
      e = '{16'sd0, (i == cnt - 1), 1'b0};
      if (n <= cut_cache[key]) begin
        m = sine_mag(32'(n) * inc, neg);
        r = ({16'd0, m} * {17'd0, vol} + 33'd16384) >> 15;
        if (neg) begin
          if (r > 33'd32768) r = 33'd32768;
          e.sample = 16'(17'h10000 - r[16:0]);
        end else begin
          if (r > 33'd32767) r = 33'd32767;
          e.sample = 16'(r);
        end
      end
      expected_samples.push_back(e);
    end
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(input logic [6:0] key, input logic [14:0] start,
                              input logic [6:0] cnt, input logic [15:0] vol, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.key          <= key;
    in_ch.start_offset <= start;
    in_ch.count        <= cnt;
    in_ch.volume       <= vol;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(key, start, cnt, vol);
    requests++;
  endtask

  // result side: random stalls, a counted hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      out_ch.ready <= 1'b0;
      hold_req--;
    end else if (!rx_idling_on) begin
      out_ch.ready <= 1'b1;
    end else if (idle_cycles > 0) begin
      out_ch.ready <= 1'b0;
      idle_cycles--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) idle_cycles = idle_len();
    end
  end

  always @(posedge clk) begin
    sample_exp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample %0d last %0b err %0b", out_ch.sample, out_ch.last,
                   out_ch.range_error);
      end else begin
        e = expected_samples.pop_front();
        if (out_ch.sample !== e.sample || out_ch.last !== e.last ||
            out_ch.range_error !== e.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample %0d: exp %0d/%0b/%0b got %0d/%0b/%0b", checked, e.sample,
                     e.last, e.range_error, out_ch.sample, out_ch.last, out_ch.range_error);
        end
      end
    end
  end

  // watchdog on cycles with no request and no sample moving
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int pick_key();
    return fast_keys[$urandom_range(0, fast_keys.size() - 1)];
  endfunction

  task automatic test_bad_keys();
    send_request(7'd84, 15'd0, 7'd1, 16'd32768, 0);
    send_request(7'd127, 15'h7fff, 7'd127, 16'hffff, 1);
    send_request(7'd100, 15'd5, 7'd0, 16'd100, 0);
  endtask

  task automatic test_run_limits();
    send_request(7'd0, 15'd10, 7'd0, 16'd32768, 0);
    send_request(7'd0, 15'd0, 7'd65, 16'd32768, 2);
    send_request(7'd0, 15'd0, 7'd127, 16'd32768, 0);
    send_request(7'd0, 15'd22049, 7'd2, 16'd32768, 0);
    send_request(7'd0, 15'h7fff, 7'd1, 16'd32768, 0);
    send_request(7'd0, 15'd22049, 7'd1, 16'd32768, 0);
    send_request(7'd0, 15'd21986, 7'd64, 16'd32768, 3);
  endtask

  task automatic test_extremes();
    send_request(7'd0, 15'd0, 7'd64, 16'd32768, 0);
    send_request(7'd0, 15'd0, 7'd8, 16'd0, 0);
    send_request(7'd0, 15'd100, 7'd16, 16'hffff, 1);
    send_request(7'd83, 15'd0, 7'd64, 16'd32768, 0);
    send_request(7'd83, 15'd16384, 7'd32, 16'd32767, 0);
    send_request(7'd83, 15'd22000, 7'd50, 16'd1, 0);
    // straddle the cutoff so the zero region shows up
    send_request(7'd0, 15'(cut_probe[0] - 15'd3), 7'd8, 16'd40000, 0);
    send_request(7'd83, 15'(cut_probe[83] - 15'd3), 7'd8, 16'd32768, 0);
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 10; i++)
      send_request(7'(pick_key()), 15'($urandom_range(0, 1000)), 7'd64, 16'd32768, 0);
  endtask

  task automatic test_random(input int num);
    int k, c, s, sel;
    for (int i = 0; i < num; i++) begin
      k   = pick_key();
      c   = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 32);
      s   = $urandom_range(0, nswp_pkg::NOTE_SAMPLES - c);
      sel = $urandom_range(0, 19);
      if (sel == 0) k = $urandom_range(84, 127);
      else if (sel == 1) c = $urandom_range(65, 127);
      else if (sel == 2) s = $urandom_range(nswp_pkg::NOTE_SAMPLES - c + 1, 32767);
      else if (sel == 3) c = 0;
      else if (sel < 7) s = (int'(cut_probe[k]) - c / 2 < 0) ? 0 :
                            (int'(cut_probe[k]) - c / 2 > nswp_pkg::NOTE_SAMPLES - c) ?
                            nswp_pkg::NOTE_SAMPLES - c : int'(cut_probe[k]) - c / 2;
      if (i == num / 2) rx_idling_on = 1'b0;
      if (i == num * 3 / 4) rx_idling_on = 1'b1;
      send_request(7'(k), 15'(s), 7'(c), 16'($urandom_range(0, 65535)),
                   (i % 40 < 8) ? 0 : idle_len());
    end
  endtask

  initial begin
    int wait_cycles;
    mismatches   = 0;
    checked      = 0;
    requests     = 0;
    hold_req     = 0;
    idle_cycles  = 0;
    rx_idling_on = 1'b1;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.key          <= '0;
    in_ch.start_offset <= '0;
    in_ch.count        <= '0;
    in_ch.volume       <= '0;
    for (int k = 0; k < nswp_pkg::NUM_KEYS; k++) begin
      cut_known[k] = 1'b0;
      cut_probe[k] = walk_cutoff(k);
      // keys with a short cutoff walk keep the run length sane
      if (nswp_pkg::NOTE_SAMPLES - 1 - int'(cut_probe[k]) <= 3000) fast_keys.push_back(k);
    end
    if (fast_keys.size() == 0) fast_keys.push_back(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_keys();
    test_run_limits();
    test_extremes();
    test_backpressure();
    test_random(300);
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("%0d requests sent, %0d samples checked over %0d fast keys plus keys 0 and 83",
             requests, checked, fast_keys.size());
    $display("bad keys, empty and oversized runs, cutoff zero region, long result stall");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d samples missing", mismatches, expected_samples.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
